>>> rtl/gipr_pkg.sv
// Shared types, constants and helper functions of the input report parser.
// No dependencies; the front end, descriptor queue, back end and top level import this package.
`default_nettype none

package gipr_pkg;

	// Byte buffer geometry: two report banks of STORE_BYTES bytes each
	localparam int STORE_BYTES = 38;
	localparam int IDX_W       = $clog2(STORE_BYTES);
	localparam int ADDR_W      = IDX_W + 1;
	localparam int RAM_DEPTH   = 2 ** ADDR_W;

	// Report ids and minimum lengths
	localparam logic [7:0] ID_PRIMARY  = 8'h01;
	localparam logic [7:0] ID_EXTENDED = 8'h31;
	localparam logic [7:0] MIN_SHORT   = 8'd10;
	localparam logic [7:0] MIN_EXT     = 8'd17;
	localparam logic [7:0] MIN_EXT_OFS = 8'd16;
	localparam logic [7:0] COUNT_MAX   = 8'hff;

	// Byte positions inside the extended payload
	localparam logic [IDX_W-1:0] POS_DPAD   = IDX_W'(7);
	localparam logic [IDX_W-1:0] POS_BTN1   = IDX_W'(8);
	localparam logic [IDX_W-1:0] POS_BTN2   = IDX_W'(9);
	localparam logic [IDX_W-1:0] POS_BATT   = IDX_W'(10);
	localparam logic [IDX_W-1:0] POS_IMU    = IDX_W'(15);
	localparam logic [IDX_W-1:0] POS_TOUCH0 = IDX_W'(29);
	localparam logic [IDX_W-1:0] POS_TOUCH1 = IDX_W'(33);

	// Length thresholds of the optional groups, before the id offset
	localparam logic [7:0] NEED_BTN2  = 8'd9;
	localparam logic [7:0] NEED_BATT  = 8'd10;
	localparam logic [7:0] NEED_IMU   = 8'd27;
	localparam logic [7:0] NEED_TOUCH = 8'd37;

	// Result field codes
	localparam logic [4:0] FC_STATUS  = 5'd0;
	localparam logic [4:0] FC_LX      = 5'd1;
	localparam logic [4:0] FC_LY      = 5'd2;
	localparam logic [4:0] FC_RX      = 5'd3;
	localparam logic [4:0] FC_RY      = 5'd4;
	localparam logic [4:0] FC_L2      = 5'd5;
	localparam logic [4:0] FC_R2      = 5'd6;
	localparam logic [4:0] FC_DPAD    = 5'd7;
	localparam logic [4:0] FC_BUTTONS = 5'd8;
	localparam logic [4:0] FC_BATTERY = 5'd9;
	localparam logic [4:0] FC_GYRO_X  = 5'd10;
	localparam logic [4:0] FC_GYRO_Y  = 5'd11;
	localparam logic [4:0] FC_GYRO_Z  = 5'd12;
	localparam logic [4:0] FC_ACC_X   = 5'd13;
	localparam logic [4:0] FC_ACC_Y   = 5'd14;
	localparam logic [4:0] FC_ACC_Z   = 5'd15;
	localparam logic [4:0] FC_T0_ACT  = 5'd16;
	localparam logic [4:0] FC_T0_ID   = 5'd17;
	localparam logic [4:0] FC_T0_X    = 5'd18;
	localparam logic [4:0] FC_T0_Y    = 5'd19;
	localparam logic [4:0] FC_T1_ACT  = 5'd20;
	localparam logic [4:0] FC_T1_ID   = 5'd21;
	localparam logic [4:0] FC_T1_X    = 5'd22;
	localparam logic [4:0] FC_T1_Y    = 5'd23;
	localparam logic [4:0] FC_LAST    = FC_T1_Y;

	// Status values
	localparam logic [15:0] ST_OK    = 16'd0;
	localparam logic [15:0] ST_SHORT = 16'd1;

	localparam logic [3:0] DPAD_NONE = 4'd8;

	// One finished report waiting for the back end
	typedef struct packed {
		logic       bank;
		logic [7:0] size;
		logic [7:0] id;
		logic       wireless;
	} desc_t;

	// Bank handed back once every read of a run is issued
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	function automatic logic [15:0] dpad_of(input logic [7:0] b0);
		logic [3:0] d;
		d = b0[3:0];
		return (d <= DPAD_NONE) ? {12'd0, d} : {12'd0, DPAD_NONE};
	endfunction

	function automatic logic [15:0] buttons_of(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic mute_ok);
		return {1'b0, mute_ok & b2[2], b2[1:0], b1, b0[7:4]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/gipr_report_if.sv
// Report byte channel: valid/ready with one byte and a last-byte flag.
// Standalone; no package needed.
`default_nettype none

interface gipr_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       final_byte;

	modport source(output valid, output report_byte, output final_byte, input ready);
	modport sink(input valid, input report_byte, input final_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/gipr_result_if.sv
// Result channel: valid/ready with field code, signed value and run end flag.
// Standalone; no package needed.
`default_nettype none

interface gipr_result_if;
	logic               valid;
	logic               ready;
	logic        [4:0]  field_code;
	logic signed [15:0] field_value;
	logic               run_end;

	modport source(output valid, output field_code, output field_value, output run_end,
		input ready);
	modport sink(input valid, input field_code, input field_value, input run_end,
		output ready);
endinterface

`default_nettype wire

>>> rtl/gipr_cfg_if.sv
// Configuration write channel: valid/ready with the wireless link bit.
// Standalone; no package needed.
`default_nettype none

interface gipr_cfg_if;
	logic valid;
	logic ready;
	logic wireless_link;

	modport source(output valid, output wireless_link, input ready);
	modport sink(input valid, input wireless_link, output ready);
endinterface

`default_nettype wire

>>> rtl/gamepad_input_report_parser.sv
// Top level of the controller input report parser: front end, descriptor
// queue, two-bank byte buffer and back end. Depends on gipr_pkg and the gipr_* files.
`default_nettype none

// Report bytes are taken at one per cycle while input is not stalled into one of
// two 38-byte banks of a two-read-port buffer; the length counts up to 255. The
// last byte queues the report and switches banks, so the next report streams in
// while the back end emits the current one. The back end gives one result per
// cycle while the result channel is ready: the status and, for a valid report,
// 23 field results; a too-short report gives the status alone. The status passes
// from the transfer of the last byte through the descriptor queue, the run
// registers, the buffer read and the output register. Byte input stalls only when
// both banks hold reports whose runs have not yet been read out. The wireless_link
// register may be written at any time but is sampled into each report at its last
// byte.
module gamepad_input_report_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	gipr_report_if.sink   report,
	gipr_result_if.source result,
	gipr_cfg_if.sink      cfg
);
	import gipr_pkg::*;

	logic              push;
	desc_t             push_desc;
	desc_t             head;
	logic              fifo_empty;
	logic              fifo_full;
	logic              pop;
	release_t          release_bank;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr0;
	logic [ADDR_W-1:0] rd_addr1;
	logic [7:0]        rd_data0;
	logic [7:0]        rd_data1;

	gipr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.report       (report),
		.cfg          (cfg),
		.release_bank (release_bank),
		.fifo_full    (fifo_full),
		.push         (push),
		.push_desc    (push_desc),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	gipr_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	gipr_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_buf (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1)
	);

	gipr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (fifo_empty),
		.head         (head),
		.pop          (pop),
		.release_bank (release_bank),
		.rd_en        (rd_en),
		.rd_addr0     (rd_addr0),
		.rd_addr1     (rd_addr1),
		.rd_data0     (rd_data0),
		.rd_data1     (rd_data1),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/gipr_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module gipr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
	output logic      [WIDTH-1:0]         rd_data0,
	output logic      [WIDTH-1:0]         rd_data1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read ports; data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0 <= mem_q[rd_addr0];
			rd_data1 <= mem_q[rd_addr1];
		end
	end

endmodule

`default_nettype wire

>>> rtl/gipr_front.sv
// Front end: takes report bytes, writes them to the current bank, counts length
// and queues a descriptor at the last byte. Depends on gipr_pkg, gipr_report_if, gipr_cfg_if.
`default_nettype none

module gipr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	gipr_report_if.sink                        report,
	gipr_cfg_if.sink                           cfg,
	input  wire gipr_pkg::release_t            release_bank,
	input  wire logic                          fifo_full,
	output logic                               push,
	output gipr_pkg::desc_t                    push_desc,
	output logic                               wr_en,
	output logic [gipr_pkg::ADDR_W-1:0]        wr_addr,
	output logic [7:0]                         wr_data
);
	import gipr_pkg::*;

	logic       wireless_q;
	logic [7:0] count_q;
	logic [7:0] id_q;
	logic       bank_q;
	logic [1:0] busy_q;
	logic       xfer;
	logic [7:0] count_next;

	// Configuration register is always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wireless_q <= 1'b0;
		end else if (cfg.valid) begin
			wireless_q <= cfg.wireless_link;
		end
	end

	// Stall while the bank being filled still belongs to an unfinished run or the descriptor queue is full
	assign report.ready = !busy_q[bank_q] && !fifo_full;
	assign xfer         = report.valid && report.ready;
	assign count_next   = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 8'd1;

	// Store leading bytes of the report
	assign wr_en   = xfer && (count_q < 8'(STORE_BYTES));
	assign wr_addr = {bank_q, count_q[IDX_W-1:0]};
	assign wr_data = report.report_byte;

	// Descriptor of the finished report
	assign push               = xfer && report.final_byte;
	assign push_desc.bank     = bank_q;
	assign push_desc.size     = count_next;
	assign push_desc.id       = (count_q == 8'd0) ? report.report_byte : id_q;
	assign push_desc.wireless = wireless_q;

	// Count bytes, switch banks at the end of a report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			if (xfer) begin
				if (report.final_byte) begin
					count_q <= 8'd0;
					bank_q  <= !bank_q;
				end else begin
					count_q <= count_next;
				end
			end
			if (release_bank.valid) begin
				busy_q[release_bank.bank] <= 1'b0;
			end
			if (push) begin
				busy_q[bank_q] <= 1'b1;
			end
		end
	end

	// Hold the id byte for classification
	always_ff @(posedge clk) begin
		if (xfer && count_q == 8'd0) begin
			id_q <= report.report_byte;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gipr_desc_fifo.sv
// Two-entry descriptor queue between front and back end.
// Depends on gipr_pkg.
`default_nettype none

module gipr_desc_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire gipr_pkg::desc_t push_desc,
	input  wire logic            pop,
	output gipr_pkg::desc_t      head,
	output logic                 empty,
	output logic                 full
);
	import gipr_pkg::*;

	desc_t      entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;

	assign head  = entry_q[rptr_q];
	assign empty = (fill_q == 2'd0);
	assign full  = (fill_q == 2'd2);

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gipr_back.sv
// Back end: walks the field codes of one report, reads its bank through the
// two-port buffer and forms each result. Depends on gipr_pkg, gipr_result_if.
`default_nettype none

module gipr_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fifo_empty,
	input  wire gipr_pkg::desc_t        head,
	output logic                        pop,
	output gipr_pkg::release_t          release_bank,
	output logic                        rd_en,
	output logic [gipr_pkg::ADDR_W-1:0] rd_addr0,
	output logic [gipr_pkg::ADDR_W-1:0] rd_addr1,
	input  wire logic [7:0]             rd_data0,
	input  wire logic [7:0]             rd_data1,
	gipr_result_if.source               result
);
	import gipr_pkg::*;

	// Current run
	logic       active_q;
	logic [4:0] code_q;
	logic       bank_q;
	logic [7:0] size_q;
	logic       short_q;
	logic       off_q;
	logic       ok_q;

	// Read-data stage
	logic       valid_s2;
	logic [4:0] code_s2;
	logic       end_s2;
	logic       ok_s2;
	logic       short_s2;
	logic       b2en_s2;
	logic       batten_s2;
	logic       imuen_s2;
	logic       touchen_s2;
	logic [7:0] b0_q;

	// Output register
	logic        out_valid_q;
	logic [4:0]  out_code_q;
	logic [15:0] out_value_q;
	logic        out_end_q;

	logic       out_free;
	logic       move_s2;
	logic       free_s2;
	logic       issue;
	logic       last_issue;
	logic       head_short;
	logic       head_off;
	logic       head_ok;
	logic [7:0] off8;
	logic [IDX_W-1:0] base0;
	logic [IDX_W-1:0] base1;
	logic [IDX_W-1:0] idx0;
	logic [IDX_W-1:0] idx1;
	logic [15:0] value;

	// Handshake chain from the output back to the issue point
	assign out_free   = !out_valid_q || result.ready;
	assign move_s2    = valid_s2 && out_free;
	assign free_s2    = !valid_s2 || move_s2;
	assign issue      = active_q && free_s2;
	assign last_issue = issue && (code_q == FC_LAST || !ok_q);
	assign pop        = !fifo_empty && (!active_q || last_issue);

	assign release_bank.valid = last_issue;
	assign release_bank.bank  = bank_q;

	// Classify the queued report
	assign head_short = head.wireless && (head.id == ID_PRIMARY);
	assign head_off   = !head_short && (head.id == ID_PRIMARY || head.id == ID_EXTENDED);
	assign head_ok    = head_short ? (head.size >= MIN_SHORT)
		: (head.size >= MIN_EXT && head.size >= MIN_EXT_OFS + {7'd0, head_off});

	// Load the next run, advance the code counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			code_q   <= FC_STATUS;
		end else if (pop) begin
			active_q <= 1'b1;
			code_q   <= FC_STATUS;
		end else if (last_issue) begin
			active_q <= 1'b0;
		end else if (issue) begin
			code_q <= code_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bank_q  <= head.bank;
			size_q  <= head.size;
			short_q <= head_short;
			off_q   <= head_off;
			ok_q    <= head_ok;
		end
	end

	// Byte positions of each field, before the id offset
	always_comb begin
		base0 = '0;
		base1 = '0;
		if (short_q) begin
			case (code_q)
				FC_LX, FC_LY, FC_RX, FC_RY: base0 = IDX_W'(code_q);
				FC_L2:      base0 = IDX_W'(8);
				FC_R2:      base0 = IDX_W'(9);
				FC_DPAD:    base0 = IDX_W'(5);
				FC_BUTTONS: begin
					base0 = IDX_W'(6);
					base1 = IDX_W'(7);
				end
				default:    base0 = '0;
			endcase
		end else begin
			case (code_q)
				FC_LX, FC_LY, FC_RX, FC_RY, FC_L2, FC_R2:
					base0 = IDX_W'(code_q) - IDX_W'(1);
				FC_DPAD:    base0 = POS_DPAD;
				FC_BUTTONS: begin
					base0 = POS_BTN1;
					base1 = POS_BTN2;
				end
				FC_BATTERY: base0 = POS_BATT;
				FC_GYRO_X, FC_GYRO_Y, FC_GYRO_Z, FC_ACC_X, FC_ACC_Y, FC_ACC_Z: begin
					base0 = POS_IMU + {code_q[IDX_W-2:0] - (IDX_W-1)'(FC_GYRO_X), 1'b0};
					base1 = base0 + IDX_W'(1);
				end
				FC_T0_ACT, FC_T0_ID: base0 = POS_TOUCH0;
				FC_T0_X: begin
					base0 = POS_TOUCH0 + IDX_W'(1);
					base1 = POS_TOUCH0 + IDX_W'(2);
				end
				FC_T0_Y: begin
					base0 = POS_TOUCH0 + IDX_W'(2);
					base1 = POS_TOUCH0 + IDX_W'(3);
				end
				FC_T1_ACT, FC_T1_ID: base0 = POS_TOUCH1;
				FC_T1_X: begin
					base0 = POS_TOUCH1 + IDX_W'(1);
					base1 = POS_TOUCH1 + IDX_W'(2);
				end
				FC_T1_Y: begin
					base0 = POS_TOUCH1 + IDX_W'(2);
					base1 = POS_TOUCH1 + IDX_W'(3);
				end
				default: base0 = '0;
			endcase
		end
	end

	assign idx0     = base0 + {{(IDX_W-1){1'b0}}, off_q};
	assign idx1     = base1 + {{(IDX_W-1){1'b0}}, off_q};
	assign rd_en    = issue;
	assign rd_addr0 = {bank_q, idx0};
	assign rd_addr1 = {bank_q, idx1};
	assign off8     = {7'd0, off_q};

	// Register the field's control next to the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			code_s2    <= code_q;
			end_s2     <= (code_q == FC_LAST) || !ok_q;
			ok_s2      <= ok_q;
			short_s2   <= short_q;
			b2en_s2    <= size_q > off8 + NEED_BTN2;
			batten_s2  <= size_q > off8 + NEED_BATT;
			imuen_s2   <= size_q >= off8 + NEED_IMU;
			touchen_s2 <= size_q >= off8 + NEED_TOUCH;
		end
		if (move_s2 && code_s2 == FC_DPAD) begin
			b0_q <= rd_data0;
		end
	end

	// Form the field value from the bytes read
	always_comb begin
		value = 16'd0;
		case (code_s2)
			FC_STATUS: value = ok_s2 ? ST_OK : ST_SHORT;
			FC_LX, FC_LY, FC_RX, FC_RY, FC_L2, FC_R2: value = {8'd0, rd_data0};
			FC_DPAD:   value = dpad_of(rd_data0);
			FC_BUTTONS: begin
				if (short_s2) begin
					value = buttons_of(b0_q, rd_data0, rd_data1, 1'b0);
				end else begin
					value = buttons_of(b0_q, rd_data0, b2en_s2 ? rd_data1 : 8'd0, 1'b1);
				end
			end
			FC_BATTERY: value = (!short_s2 && batten_s2) ? {8'd0, rd_data0} : 16'd0;
			FC_GYRO_X, FC_GYRO_Y, FC_GYRO_Z, FC_ACC_X, FC_ACC_Y, FC_ACC_Z:
				value = (!short_s2 && imuen_s2) ? {rd_data1, rd_data0} : 16'd0;
			FC_T0_ACT, FC_T1_ACT:
				value = (!short_s2 && touchen_s2) ? {15'd0, !rd_data0[7]} : 16'd0;
			FC_T0_ID, FC_T1_ID:
				value = (!short_s2 && touchen_s2) ? {9'd0, rd_data0[6:0]} : 16'd0;
			FC_T0_X, FC_T1_X:
				value = (!short_s2 && touchen_s2) ? {4'd0, rd_data1[3:0], rd_data0} : 16'd0;
			FC_T0_Y, FC_T1_Y:
				value = (!short_s2 && touchen_s2) ? {4'd0, rd_data1, rd_data0[7:4]} : 16'd0;
			default: value = 16'd0;
		endcase
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			out_code_q  <= code_s2;
			out_value_q <= value;
			out_end_q   <= end_s2;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.field_code  = out_code_q;
	assign result.field_value = $signed(out_value_q);
	assign result.run_end     = out_end_q;

endmodule

`default_nettype wire
